>>> design/crcfp_pkg.sv
// Shared types, constants and the CRC-16/CCITT byte step for the frame parser.
package crcfp_pkg;

	// Default payload limit of a frame
	localparam int MAX_PAYLOAD_DEF = 64;

	// Frame layout
	localparam logic [6:0] HDR_BYTES  = 7'd10;
	localparam logic [6:0] CRC_BYTES  = 7'd2;
	localparam logic [6:0] POS_VER    = 7'd2;
	localparam logic [6:0] POS_FLAGS  = 7'd3;
	localparam logic [6:0] POS_CMD_LO = 7'd4;
	localparam logic [6:0] POS_CMD_HI = 7'd5;
	localparam logic [6:0] POS_SEQ_LO = 7'd6;
	localparam logic [6:0] POS_SEQ_HI = 7'd7;
	localparam logic [6:0] POS_LEN_LO = 7'd8;
	localparam logic [6:0] POS_LEN_HI = 7'd9;

	// CRC-16/CCITT, MSB first, no final xor
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Configuration register indexes
	localparam logic CFG_SB_FIRST  = 1'b0;
	localparam logic CFG_SB_SECOND = 1'b1;

	// Reset values of the start bytes
	localparam logic [7:0] SB_FIRST_RST  = 8'hA5;
	localparam logic [7:0] SB_SECOND_RST = 8'h5A;

	// Result codes
	typedef enum logic [1:0] {
		EV_GOOD = 2'd0,
		EV_LEN  = 2'd1,
		EV_CRC  = 2'd2
	} ev_code_t;

	// Header fields of the frame being parsed
	typedef struct packed {
		logic [7:0]  version;
		logic [7:0]  flags;
		logic [15:0] command;
		logic [15:0] seq_num;
		logic [6:0]  plen;
	} frame_hdr_t;

	// Parser to emitter: one-cycle event of a finished frame
	typedef struct packed {
		logic     load;  // single result: error or empty good frame
		logic     run;   // good frame with payload, start the run
		ev_code_t code;
	} parse_evt_t;

	// Emitter to parser
	typedef struct packed {
		logic busy;       // payload run in progress
		logic slot_free;  // output register can take a result this cycle
	} emit_stat_t;

	// One byte through the CRC, bit at a time
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> design/crcfp_store.sv
// Payload byte store: one write port, one registered read port.
module crcfp_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          re,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> design/crcfp_parser.sv
// Start-byte hunt, header capture, CRC accumulation and payload writes.
module crcfp_parser
	import crcfp_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_DEF,
	parameter int AW                = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [7:0]    cfg_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    rx_byte,
	input  emit_stat_t    stat,
	output parse_evt_t    evt,
	output frame_hdr_t    hdr,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data
);

	typedef enum logic [1:0] {
		PH_HUNT1   = 2'd0,
		PH_HUNT2   = 2'd1,
		PH_COLLECT = 2'd2
	} phase_t;

	localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD_BYTES);

	phase_t      phase_q;
	logic [6:0]  count_q;
	logic [6:0]  exp_q;
	logic [15:0] crc_q;
	logic [7:0]  sb_first_q;
	logic [7:0]  sb_second_q;
	logic [7:0]  len_lo_q;
	logic [7:0]  crc_lo_q;
	frame_hdr_t  hdr_q;

	logic        accept;
	logic        collect;
	logic [15:0] crc_next;
	logic        crc_upd;
	logic [15:0] len16;
	logic        len_bad;
	logic        at_len;
	logic        at_end;
	logic        at_crc_lo;
	logic        in_payload;
	logic        crc_ok;
	logic        final_pos;
	logic [6:0]  pay_idx;

	// Position decode of the incoming byte
	always_comb begin
		collect    = (phase_q == PH_COLLECT);
		crc_next   = crc16_step(crc_q, rx_byte);
		crc_upd    = (count_q >= POS_VER) &&
		             ((count_q < HDR_BYTES) || (count_q + CRC_BYTES < exp_q));
		len16      = {rx_byte, len_lo_q};
		len_bad    = (len16 > MAX_LEN);
		at_len     = (count_q == POS_LEN_HI);
		at_end     = (count_q >= HDR_BYTES) && (count_q + 7'd1 == exp_q);
		at_crc_lo  = (count_q >= HDR_BYTES) && (count_q + CRC_BYTES == exp_q);
		in_payload = (count_q >= HDR_BYTES) && (count_q + CRC_BYTES < exp_q);
		crc_ok     = ({rx_byte, crc_lo_q} == crc_q);
		final_pos  = collect && (at_len || at_end);
		pay_idx    = count_q - HDR_BYTES;
	end

	// Hold each byte of a payload run, and the length or last frame byte while the output register is full and stalled
	assign in_stall = stat.busy || (final_pos && !stat.slot_free);
	assign accept   = in_valid && !in_stall;

	// Frame outcome towards the emitter
	always_comb begin
		evt.load = accept && collect &&
		           ((at_len && len_bad) || (at_end && (!crc_ok || hdr_q.plen == 7'd0)));
		evt.run  = accept && collect && at_end && crc_ok && (hdr_q.plen != 7'd0);
		evt.code = at_len ? EV_LEN : (crc_ok ? EV_GOOD : EV_CRC);
	end

	assign hdr     = hdr_q;
	assign wr_en   = accept && collect && in_payload;
	assign wr_addr = pay_idx[AW-1:0];
	assign wr_data = rx_byte;

	// Control state and start-byte registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT1;
			count_q     <= '0;
			exp_q       <= '0;
			crc_q       <= CRC_INIT;
			sb_first_q  <= SB_FIRST_RST;
			sb_second_q <= SB_SECOND_RST;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_SB_FIRST) begin
					sb_first_q <= cfg_data;
				end else begin
					sb_second_q <= cfg_data;
				end
			end
			if (accept) begin
				case (phase_q)
					PH_HUNT2: begin
						if (rx_byte == sb_second_q) begin
							phase_q <= PH_COLLECT;
							count_q <= POS_VER;
							crc_q   <= CRC_INIT;
						end else if (rx_byte == sb_first_q) begin
							count_q <= 7'd1;
						end else begin
							phase_q <= PH_HUNT1;
						end
					end
					PH_COLLECT: begin
						count_q <= count_q + 7'd1;
						if (crc_upd) begin
							crc_q <= crc_next;
						end
						if (at_len) begin
							if (len_bad) begin
								phase_q <= PH_HUNT1;
							end else begin
								exp_q <= len16[6:0] + HDR_BYTES + CRC_BYTES;
							end
						end
						if (at_end) begin
							phase_q <= PH_HUNT1;
						end
					end
					default: begin
						if (rx_byte == sb_first_q) begin
							phase_q <= PH_HUNT2;
							count_q <= 7'd1;
						end else begin
							phase_q <= PH_HUNT1;
						end
					end
				endcase
			end
		end
	end

	// Header and CRC byte capture
	always_ff @(posedge clk) begin
		if (accept && collect) begin
			case (count_q)
				POS_VER:    hdr_q.version         <= rx_byte;
				POS_FLAGS:  hdr_q.flags           <= rx_byte;
				POS_CMD_LO: hdr_q.command[7:0]    <= rx_byte;
				POS_CMD_HI: hdr_q.command[15:8]   <= rx_byte;
				POS_SEQ_LO: hdr_q.seq_num[7:0]    <= rx_byte;
				POS_SEQ_HI: hdr_q.seq_num[15:8]   <= rx_byte;
				POS_LEN_LO: len_lo_q              <= rx_byte;
				POS_LEN_HI: hdr_q.plen            <= len16[6:0];
				default: begin
					if (at_crc_lo) begin
						crc_lo_q <= rx_byte;
					end
				end
			endcase
		end
	end

endmodule

>>> design/crcfp_emitter.sv
// Output register and the sequencer that reads a payload run out of the store.
module crcfp_emitter
	import crcfp_pkg::*;
#(
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  parse_evt_t    evt,
	input  frame_hdr_t    hdr,
	output emit_stat_t    stat,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  logic [7:0]    rd_data,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    event_code,
	output logic [7:0]    hdr_version,
	output logic [7:0]    hdr_flags,
	output logic [15:0]   hdr_command,
	output logic [15:0]   hdr_sequence,
	output logic [6:0]    payload_count,
	output logic [7:0]    payload_byte,
	output logic          byte_valid,
	output logic          last_item
);

	typedef enum logic [1:0] {
		EM_IDLE = 2'd0,
		EM_READ = 2'd1,
		EM_SEND = 2'd2
	} em_state_t;

	em_state_t  state_q;
	frame_hdr_t run_hdr_q;
	logic [6:0] ptr_q;
	logic       out_valid_q;
	logic [1:0] code_q;
	logic [7:0] ver_q;
	logic [7:0] flags_q;
	logic [15:0] cmd_q;
	logic [15:0] seq_q;
	logic [6:0] cnt_q;
	logic [7:0] pbyte_q;
	logic       bvalid_q;
	logic       last_q;

	logic slot_free;
	logic run_last;

	assign slot_free      = !out_valid_q || !out_stall;
	assign run_last       = (ptr_q + 7'd1 == run_hdr_q.plen);
	assign stat.busy      = (state_q != EM_IDLE);
	assign stat.slot_free = slot_free;
	assign rd_en          = (state_q == EM_READ);
	assign rd_addr        = ptr_q[AW-1:0];

	// Sequencer and output register: each beat via EM_READ, EM_SEND
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EM_IDLE;
			run_hdr_q   <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
			code_q      <= '0;
			ver_q       <= '0;
			flags_q     <= '0;
			cmd_q       <= '0;
			seq_q       <= '0;
			cnt_q       <= '0;
			pbyte_q     <= '0;
			bvalid_q    <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				EM_IDLE: begin
					if (evt.load) begin
						// error or empty frame: a single closing beat
						out_valid_q <= 1'b1;
						code_q      <= evt.code;
						pbyte_q     <= '0;
						bvalid_q    <= 1'b0;
						last_q      <= 1'b1;
						cnt_q       <= '0;
						if (evt.code == EV_GOOD) begin
							ver_q   <= hdr.version;
							flags_q <= hdr.flags;
							cmd_q   <= hdr.command;
							seq_q   <= hdr.seq_num;
						end else begin
							ver_q   <= '0;
							flags_q <= '0;
							cmd_q   <= '0;
							seq_q   <= '0;
						end
					end
					if (evt.run) begin
						run_hdr_q <= hdr;
						ptr_q     <= '0;
						state_q   <= EM_READ;
					end
				end
				EM_READ: begin
					state_q <= EM_SEND;
				end
				EM_SEND: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						code_q      <= EV_GOOD;
						ver_q       <= run_hdr_q.version;
						flags_q     <= run_hdr_q.flags;
						cmd_q       <= run_hdr_q.command;
						seq_q       <= run_hdr_q.seq_num;
						cnt_q       <= run_hdr_q.plen;
						pbyte_q     <= rd_data;
						bvalid_q    <= 1'b1;
						last_q      <= run_last;
						ptr_q       <= ptr_q + 7'd1;
						state_q     <= run_last ? EM_IDLE : EM_READ;
					end
				end
				default: begin
					state_q <= EM_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign event_code    = code_q;
	assign hdr_version   = ver_q;
	assign hdr_flags     = flags_q;
	assign hdr_command   = cmd_q;
	assign hdr_sequence  = seq_q;
	assign payload_count = cnt_q;
	assign payload_byte  = pbyte_q;
	assign byte_valid    = bvalid_q;
	assign last_item     = last_q;

endmodule

>>> design/crc16_frame_stream_parser_core.sv
// Top level of the CRC-16 framed byte-stream parser.
//
// Bytes are taken one per cycle while in_stall is low: the parser hunts the
// two start bytes, captures the 10-byte header, runs CRC-16/CCITT over version
// through payload and writes payload bytes into a one-port-write, one-port-read
// store. The length byte and the last CRC byte wait on in_stall only while
// the output register holds a result that out_stall is holding back.
// A length error, a CRC error or an empty good frame yields one result right
// away. A good frame of N payload bytes yields N results, each a store read,
// then an output register load, held by any output stall; in_stall is high
// for the whole run. The store needs no clearing after reset.
module crc16_frame_stream_parser_core
	import crcfp_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_code,
	output logic [7:0]  hdr_version,
	output logic [7:0]  hdr_flags,
	output logic [15:0] hdr_command,
	output logic [15:0] hdr_sequence,
	output logic [6:0]  payload_count,
	output logic [7:0]  payload_byte,
	output logic        byte_valid,
	output logic        last_item
);

	localparam int DEPTH = (MAX_PAYLOAD_BYTES > 0) ? MAX_PAYLOAD_BYTES : 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	parse_evt_t    evt;
	frame_hdr_t    hdr;
	emit_stat_t    stat;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	crcfp_parser #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
		.AW(AW)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.stat(stat),
		.evt(evt),
		.hdr(hdr),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	crcfp_store #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.re(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	crcfp_emitter #(
		.AW(AW)
	) u_emitter (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt),
		.hdr(hdr),
		.stat(stat),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_code(event_code),
		.hdr_version(hdr_version),
		.hdr_flags(hdr_flags),
		.hdr_command(hdr_command),
		.hdr_sequence(hdr_sequence),
		.payload_count(payload_count),
		.payload_byte(payload_byte),
		.byte_valid(byte_valid),
		.last_item(last_item)
	);

endmodule

>>> dv/tb_crc16_frame_stream_parser_core.sv
// Self-checking testbench of the CRC-16 framed byte-stream parser core.
`timescale 1ns / 100ps

module tb_crc16_frame_stream_parser_core;
	import crcfp_pkg::*;

	localparam int FRAME_HDR      = 10;
	localparam int FRAME_CRC      = 2;
	localparam int PAYLOAD_LIMIT  = 64;
	localparam int STORE_DEPTH    = FRAME_HDR + PAYLOAD_LIMIT + FRAME_CRC;
	localparam int LONG_HOLD      = 400;
	localparam int SETTLE_CYCLES  = 150;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum logic [1:0] {
		PH_HUNT_FIRST  = 2'd0,
		PH_HUNT_SECOND = 2'd1,
		PH_COLLECT     = 2'd2
	} rx_phase_t;

	typedef struct {
		ev_code_t    code;
		logic [7:0]  version;
		logic [7:0]  flags;
		logic [15:0] command;
		logic [15:0] seqn;
		logic [6:0]  count;
		logic [7:0]  pbyte;
		logic        bvalid;
		logic        is_last;
	} frame_result_t;

	// Block ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_SB_FIRST;
	logic [7:0]  cfg_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  event_code;
	logic [7:0]  hdr_version;
	logic [7:0]  hdr_flags;
	logic [15:0] hdr_command;
	logic [15:0] hdr_sequence;
	logic [6:0]  payload_count;
	logic [7:0]  payload_byte;
	logic        byte_valid;
	logic        last_item;

	// Stimulus side
	logic [7:0]  rx_backlog[$];
	logic        in_beat_seen = 1'b0;
	logic        send_gaps = 1'b1;
	logic        recv_gaps = 1'b1;
	int          send_gap = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	int          holds_asked = 0;
	int          holds_served = 0;
	int          rx_queued = 0;
	logic [7:0]  gen_sb_first = SB_FIRST_RST;
	logic [7:0]  gen_sb_second = SB_SECOND_RST;

	// Parser copy used for prediction
	rx_phase_t   pr_phase = PH_HUNT_FIRST;
	int          pr_count = 0;
	int          pr_total = 0;
	logic [15:0] pr_crc = CRC_INIT;
	logic [7:0]  pr_store [0:STORE_DEPTH-1];
	logic [7:0]  pr_sb_first = SB_FIRST_RST;
	logic [7:0]  pr_sb_second = SB_SECOND_RST;
	frame_result_t deframed_due[$];

	// Tallies
	int n_rx_beats = 0;
	int n_checked = 0;
	int n_mismatch = 0;
	int n_good = 0;
	int n_len_err = 0;
	int n_crc_err = 0;
	int n_settings = 1;
	int leftover = 0;

	crc16_frame_stream_parser_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_code   (event_code),
		.hdr_version  (hdr_version),
		.hdr_flags    (hdr_flags),
		.hdr_command  (hdr_command),
		.hdr_sequence (hdr_sequence),
		.payload_count(payload_count),
		.payload_byte (payload_byte),
		.byte_valid   (byte_valid),
		.last_item    (last_item)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// CRC-16/CCITT, one input bit per step
	function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] s;
		logic        fb;
		s = c;
		for (int k = 7; k >= 0; k--) begin
			fb = s[15] ^ d[k];
			s = {s[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return s;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic string show_result(input frame_result_t r);
		return {$sformatf("code=%0d ver=%02h flags=%02h cmd=%04h seq=%04h ",
				r.code, r.version, r.flags, r.command, r.seqn),
			$sformatf("cnt=%0d byte=%02h bv=%0b last=%0b",
				r.count, r.pbyte, r.bvalid, r.is_last)};
	endfunction

	task automatic parser_clear();
		pr_phase = PH_HUNT_FIRST;
		pr_count = 0;
		pr_total = 0;
		pr_crc   = CRC_INIT;
	endtask

	// Length and CRC errors carry only the code and the last flag
	task automatic push_error(input ev_code_t code);
		frame_result_t r;
		r.code    = code;
		r.version = '0;
		r.flags   = '0;
		r.command = '0;
		r.seqn    = '0;
		r.count   = '0;
		r.pbyte   = '0;
		r.bvalid  = 1'b0;
		r.is_last = 1'b1;
		deframed_due.push_back(r);
		if (code == EV_LEN)
			n_len_err++;
		else
			n_crc_err++;
	endtask

	// Advance the parser copy by one received byte, queue what it yields
	task automatic deframe_byte(input logic [7:0] b);
		int            idx;
		int            plen;
		logic [15:0]   rx_crc;
		frame_result_t r;
		case (pr_phase)
			PH_HUNT_SECOND: begin
				if (b == pr_sb_second) begin
					pr_store[1] = b;
					pr_count = 2;
					pr_phase = PH_COLLECT;
					pr_crc = CRC_INIT;
				end else if (b == pr_sb_first) begin
					// repeated first start byte restarts the hunt
					pr_store[0] = b;
					pr_count = 1;
				end else begin
					parser_clear();
				end
			end
			PH_COLLECT: begin
				idx = pr_count;
				if (idx >= STORE_DEPTH) begin
					parser_clear();
				end else begin
					pr_store[idx] = b;
					pr_count = idx + 1;
					if (idx >= 2 && (idx < FRAME_HDR || idx + FRAME_CRC < pr_total))
						pr_crc = crc_next(pr_crc, b);
					if (pr_count == FRAME_HDR) begin
						plen = int'({pr_store[9], pr_store[8]});
						if (plen > PAYLOAD_LIMIT) begin
							parser_clear();
							push_error(EV_LEN);
						end else begin
							pr_total = FRAME_HDR + plen + FRAME_CRC;
						end
					end else if (pr_count > FRAME_HDR && pr_count == pr_total) begin
						plen = pr_total - FRAME_HDR - FRAME_CRC;
						rx_crc = {pr_store[FRAME_HDR + plen + 1], pr_store[FRAME_HDR + plen]};
						if (rx_crc != pr_crc) begin
							parser_clear();
							push_error(EV_CRC);
						end else begin
							r.code    = EV_GOOD;
							r.version = pr_store[2];
							r.flags   = pr_store[3];
							r.command = {pr_store[5], pr_store[4]};
							r.seqn    = {pr_store[7], pr_store[6]};
							parser_clear();
							n_good++;
							if (plen == 0) begin
								// empty payload: one result without data
								r.count   = '0;
								r.pbyte   = '0;
								r.bvalid  = 1'b0;
								r.is_last = 1'b1;
								deframed_due.push_back(r);
							end else begin
								for (int i = 0; i < plen; i++) begin
									r.count   = 7'(plen);
									r.pbyte   = pr_store[FRAME_HDR + i];
									r.bvalid  = 1'b1;
									r.is_last = (i == plen - 1);
									deframed_due.push_back(r);
								end
							end
						end
					end else if (pr_count >= STORE_DEPTH) begin
						parser_clear();
					end
				end
			end
			default: begin
				if (b == pr_sb_first) begin
					pr_store[0] = b;
					pr_count = 1;
					pr_phase = PH_HUNT_SECOND;
				end else begin
					parser_clear();
				end
			end
		endcase
	endtask

	task automatic queue_rx(input logic [7:0] b);
		rx_backlog.push_back(b);
		rx_queued++;
	endtask

	// A byte that matches neither start byte
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (b == gen_sb_first || b == gen_sb_second);
		return b;
	endfunction

	function automatic logic [15:0] pick_plen();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 16'($urandom_range(0, 8));
		else if (r < 92)
			return 16'($urandom_range(9, 40));
		else if (r < 96)
			return 16'(PAYLOAD_LIMIT);
		return 16'($urandom_range(41, PAYLOAD_LIMIT - 1));
	endfunction

	// One frame; header only when the length is over the limit, no CRC when cut short
	task automatic queue_frame(input logic [7:0] ver, input logic [7:0] flg,
			input logic [15:0] cmd, input logic [15:0] seqn, input logic [15:0] len_field,
			input logic [15:0] crc_flip, input logic cut);
		logic [7:0]  hb [8];
		logic [7:0]  pb;
		logic [15:0] c;
		int          n;
		hb = '{ver, flg, cmd[7:0], cmd[15:8], seqn[7:0], seqn[15:8],
			len_field[7:0], len_field[15:8]};
		queue_rx(gen_sb_first);
		queue_rx(gen_sb_second);
		c = CRC_INIT;
		foreach (hb[i]) begin
			queue_rx(hb[i]);
			c = crc_next(c, hb[i]);
		end
		if (len_field <= PAYLOAD_LIMIT) begin
			n = cut ? int'($urandom_range(0, int'(len_field) - 1)) : int'(len_field);
			for (int i = 0; i < n; i++) begin
				pb = 8'($urandom);
				queue_rx(pb);
				c = crc_next(c, pb);
			end
			if (!cut) begin
				c = c ^ crc_flip;
				queue_rx(c[7:0]);
				queue_rx(c[15:8]);
			end
		end
	endtask

	// Mostly well-formed frames, the rest errors, noise and broken starts
	task automatic queue_random_traffic(input int n_beats);
		int          target;
		int          r;
		logic [15:0] len_field;
		target = rx_queued + n_beats;
		while (rx_queued < target) begin
			r = $urandom_range(0, 99);
			if (r < 62) begin
				queue_frame(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
					pick_plen(), 16'h0000, 1'b0);
			end else if (r < 72) begin
				queue_frame(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
					pick_plen(), 16'($urandom_range(1, 16'hFFFF)), 1'b0);
			end else if (r < 80) begin
				len_field = ($urandom_range(0, 3) == 0) ? 16'(PAYLOAD_LIMIT + 1)
					: 16'($urandom_range(PAYLOAD_LIMIT + 1, 16'hFFFF));
				queue_frame(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
					len_field, 16'h0000, 1'b0);
			end else if (r < 87) begin
				repeat ($urandom_range(1, 6)) queue_rx(noise_byte());
			end else if (r < 93) begin
				repeat ($urandom_range(1, 3)) queue_rx(gen_sb_first);
				queue_rx(noise_byte());
			end else if (r < 97) begin
				repeat ($urandom_range(1, 3)) queue_rx(gen_sb_first);
				queue_frame(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
					pick_plen(), 16'h0000, 1'b0);
			end else begin
				queue_frame(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom_range(1, 16)), 16'h0000, 1'b1);
			end
		end
	endtask

	// Hold off until the backlog is sent and every result is out, then let the block settle
	task automatic wait_quiet();
		do
			@(posedge clk);
		while (rx_backlog.size() != 0 || in_valid || deframed_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_start_bytes(input logic [7:0] first, input logic [7:0] second);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SB_FIRST;
		cfg_data  <= first;
		@(negedge clk);
		cfg_index <= CFG_SB_SECOND;
		cfg_data  <= second;
		@(negedge clk);
		cfg_we    <= 1'b0;
		gen_sb_first  = first;
		gen_sb_second = second;
		n_settings++;
		@(posedge clk);
	endtask

	// Sender: one byte per beat, random gaps between beats while send_gaps is set
	always @(negedge clk) begin : drive_rx
		logic       nv;
		logic [7:0] nb;
		nv = in_valid;
		nb = rx_byte;
		if (!in_valid || in_beat_seen) begin
			if (send_gap > 0) begin
				nv = 1'b0;
				send_gap--;
			end else if (rx_backlog.size() != 0) begin
				nb = rx_backlog.pop_front();
				nv = 1'b1;
				if (send_gaps)
					send_gap = pick_gap();
			end else begin
				nv = 1'b0;
			end
		end
		in_valid <= nv;
		rx_byte  <= nb;
	end

	// Receiver: random stalls while recv_gaps is set, plus the long hold-offs asked for
	always @(negedge clk) begin : drive_out_stall
		logic ns;
		if (hold_left > 0) begin
			ns = 1'b1;
			hold_left--;
		end else if (holds_served < holds_asked) begin
			holds_served++;
			hold_left = LONG_HOLD - 1;
			ns = 1'b1;
		end else if (stall_left > 0) begin
			ns = 1'b1;
			stall_left--;
		end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap();
			ns = 1'b1;
		end else begin
			ns = 1'b0;
		end
		out_stall <= ns;
	end

	// Monitor: predict on each rx beat, check each result beat
	always @(posedge clk) begin : watch_ports
		frame_result_t got;
		frame_result_t want;
		in_beat_seen <= in_valid && !in_stall;
		if (cfg_we) begin
			if (cfg_index == CFG_SB_FIRST)
				pr_sb_first = cfg_data;
			else
				pr_sb_second = cfg_data;
		end
		if (in_valid && !in_stall) begin
			n_rx_beats++;
			deframe_byte(rx_byte);
		end
		if (out_valid && !out_stall) begin
			got.code    = ev_code_t'(event_code);
			got.version = hdr_version;
			got.flags   = hdr_flags;
			got.command = hdr_command;
			got.seqn    = hdr_sequence;
			got.count   = payload_count;
			got.pbyte   = payload_byte;
			got.bvalid  = byte_valid;
			got.is_last = last_item;
			if (deframed_due.size() == 0) begin
				if (n_mismatch < 10)
					$display("result %0d not expected: %s", n_checked, show_result(got));
				n_mismatch++;
			end else begin
				want = deframed_due.pop_front();
				if (got.code !== want.code || got.version !== want.version ||
						got.flags !== want.flags || got.command !== want.command ||
						got.seqn !== want.seqn || got.count !== want.count ||
						got.pbyte !== want.pbyte || got.bvalid !== want.bvalid ||
						got.is_last !== want.is_last) begin
					if (n_mismatch < 10) begin
						$display("result %0d mismatch, expected %s", n_checked, show_result(want));
						$display("result %0d mismatch, actual   %s", n_checked, show_result(got));
					end
					n_mismatch++;
				end
			end
			n_checked++;
		end
	end

	// Watchdog: too long without any beat on either side
	always @(posedge clk) begin : watchdog
		int idle_cycles;
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d idle cycles, %0d results still due",
					idle_cycles, deframed_due.size());
				$display("tb_crc16_frame_stream_parser_core: FAIL");
				$finish;
			end
		end
	end

	initial begin : run_phases
		logic [7:0] va;
		logic [7:0] vb;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: aborted hunt, repeated start with over-length field, empty frame, CRC error
		queue_rx(gen_sb_first);
		queue_rx(8'h00);
		queue_rx(gen_sb_first);
		queue_frame(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
		queue_frame(8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		queue_frame(8'h80, 8'h01, 16'h8001, 16'h7FFE, 16'h0001, 16'h0001, 1'b0);
		queue_random_traffic(70);
		wait_quiet();

		// Extreme start bytes, with a long receiver hold-off
		set_start_bytes(8'h00, 8'hFF);
		queue_random_traffic(60);
		holds_asked++;
		wait_quiet();

		// Swapped extremes, no idling on either side
		set_start_bytes(8'hFF, 8'h00);
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		queue_random_traffic(60);
		wait_quiet();
		send_gaps = 1'b1;
		recv_gaps = 1'b1;

		// Both start bytes equal
		va = 8'($urandom);
		set_start_bytes(va, va);
		queue_random_traffic(40);
		wait_quiet();

		// Random distinct start bytes, another hold-off
		va = 8'($urandom);
		do
			vb = 8'($urandom);
		while (vb == va);
		set_start_bytes(va, vb);
		queue_random_traffic(60);
		holds_asked++;
		wait_quiet();

		// Back to the reset values
		set_start_bytes(SB_FIRST_RST, SB_SECOND_RST);
		queue_random_traffic(40);
		wait_quiet();

		leftover = deframed_due.size();
		if (leftover != 0)
			$display("%0d results never arrived", leftover);
		$display("covered %0d rx beats over %0d start-byte settings, %0d results checked",
			n_rx_beats, n_settings, n_checked);
		$display("frames: %0d good, %0d over-length, %0d crc errors; %0d mismatches",
			n_good, n_len_err, n_crc_err, n_mismatch);
		if (n_mismatch == 0 && leftover == 0)
			$display("tb_crc16_frame_stream_parser_core: PASS");
		else
			$display("tb_crc16_frame_stream_parser_core: FAIL");
		$finish;
	end

endmodule

>>> files.f
design/crcfp_pkg.sv
design/crcfp_store.sv
design/crcfp_parser.sv
design/crcfp_emitter.sv
design/crc16_frame_stream_parser_core.sv
dv/tb_crc16_frame_stream_parser_core.sv
